FILE: rtl/pwvm_pkg.sv
package pwvm_pkg;

  localparam int NUM_VOICES    = 8;
  localparam int BUFFER_LEN    = 64;
  localparam int TABLE_SIZE    = 2048;
  localparam int RAMP_STEPS    = 32;
  localparam int RIGHT_BUTTONS = 64;
  localparam int LEFT_COUNT    = 24;

  localparam int VOICE_W    = $clog2(NUM_VOICES);
  localparam int TIDX_W     = $clog2(TABLE_SIZE);
  localparam int WAVE_DEPTH = 3 * TABLE_SIZE;
  localparam int WADDR_W    = $clog2(WAVE_DEPTH);
  localparam int TICK_W     = $clog2(BUFFER_LEN + 1);
  localparam int RAMP_W     = $clog2(RAMP_STEPS + 1);
  localparam int SAMPLE_W   = 23;
  localparam int SUM_W      = 36;
  localparam int OUT_MAX    = 4194303;
  localparam int OUT_MIN    = -4194304;

  localparam logic [2:0] MODE_RIGHT_ON  = 3'd0;
  localparam logic [2:0] MODE_RIGHT_OFF = 3'd1;
  localparam logic [2:0] MODE_LEFT_ON   = 3'd2;
  localparam logic [2:0] MODE_LEFT_OFF  = 3'd3;
  localparam logic [2:0] MODE_TICK      = 3'd4;
  localparam logic [2:0] MODE_TABLE     = 3'd5;

  localparam logic [1:0] CFG_BASS_VOL   = 2'd0;
  localparam logic [1:0] CFG_CHORDS_VOL = 2'd1;
  localparam logic [1:0] CFG_MELODY_VOL = 2'd2;
  localparam logic [1:0] CFG_VIB_RATE   = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LATCH,
    OP_SCAN,
    OP_APPLY,
    OP_T_RD,
    OP_T_MUL1,
    OP_T_MUL2,
    OP_T_ACC,
    OP_T_FINISH
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [VOICE_W-1:0] vidx;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_busy;
  } stat_t;

  function automatic logic [31:0] semitone(input logic [3:0] k);
    logic [31:0] r;
    case (k)
      4'd0:    r = 32'd21500000;
      4'd1:    r = 32'd22778457;
      4'd2:    r = 32'd24132934;
      4'd3:    r = 32'd25567953;
      4'd4:    r = 32'd27088303;
      4'd5:    r = 32'd28699057;
      4'd6:    r = 32'd30405592;
      4'd7:    r = 32'd32213602;
      4'd8:    r = 32'd34129123;
      4'd9:    r = 32'd36158546;
      4'd10:   r = 32'd38308645;
      4'd11:   r = 32'd40586595;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] left_note(input logic [4:0] b);
    logic [4:0] r;
    case (b)
      5'd0:    r = 5'd5;
      5'd1:    r = 5'd0;
      5'd2:    r = 5'd17;
      5'd3:    r = 5'd12;
      5'd4:    r = 5'd7;
      5'd5:    r = 5'd2;
      5'd6:    r = 5'd19;
      5'd7:    r = 5'd14;
      5'd8:    r = 5'd9;
      5'd9:    r = 5'd4;
      5'd10:   r = 5'd21;
      5'd11:   r = 5'd16;
      5'd12:   r = 5'd11;
      5'd13:   r = 5'd6;
      5'd14:   r = 5'd23;
      5'd15:   r = 5'd18;
      5'd16:   r = 5'd1;
      5'd17:   r = 5'd8;
      5'd18:   r = 5'd13;
      5'd19:   r = 5'd20;
      5'd20:   r = 5'd3;
      5'd21:   r = 5'd10;
      5'd22:   r = 5'd15;
      5'd23:   r = 5'd22;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // m is the note offset by two octaves (0..77)
  function automatic logic [31:0] note_incr(input logic [6:0] m);
    logic [2:0]  oct;
    logic [6:0]  semi;
    logic [39:0] v;
    oct = 3'd0;
    if (m >= 7'd12) oct = 3'd1;
    if (m >= 7'd24) oct = 3'd2;
    if (m >= 7'd36) oct = 3'd3;
    if (m >= 7'd48) oct = 3'd4;
    if (m >= 7'd60) oct = 3'd5;
    if (m >= 7'd72) oct = 3'd6;
    semi = m - ({1'b0, oct, 3'b000} + {2'b00, oct, 2'b00});
    v = {8'd0, semitone(semi[3:0])} << oct;
    v = v + 40'd2;
    return v[33:2];
  endfunction

endpackage

FILE: rtl/pwvm_ctrl.sv
module pwvm_ctrl
  import pwvm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [2:0] mode,
  output logic       in_stall,
  input  stat_t      stat,
  output cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_APPLY, S_T_RD, S_T_MUL1, S_T_MUL2, S_T_ACC, S_T_DONE
  } state_t;

  localparam logic [VOICE_W-1:0] LAST_VOICE  = VOICE_W'(NUM_VOICES - 1);
  localparam logic [VOICE_W-1:0] FIRST_MELODY = VOICE_W'(2);

  state_t             state;
  logic [VOICE_W-1:0] vidx;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd.vidx = vidx;
    case (state)
      S_CLEAR:  cmd.op = OP_CLEAR;
      S_IDLE:   cmd.op = in_valid ? OP_LATCH : OP_NONE;
      S_SCAN:   cmd.op = OP_SCAN;
      S_APPLY:  cmd.op = OP_APPLY;
      S_T_RD:   cmd.op = OP_T_RD;
      S_T_MUL1: cmd.op = OP_T_MUL1;
      S_T_MUL2: cmd.op = OP_T_MUL2;
      S_T_ACC:  cmd.op = OP_T_ACC;
      S_T_DONE: cmd.op = stat.out_busy ? OP_NONE : OP_T_FINISH;
      default:  cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      vidx  <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (stat.clr_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            case (mode)
              MODE_RIGHT_ON, MODE_RIGHT_OFF: begin
                vidx  <= FIRST_MELODY;
                state <= S_SCAN;
              end
              MODE_LEFT_ON, MODE_LEFT_OFF, MODE_TABLE: state <= S_APPLY;
              MODE_TICK: begin
                vidx  <= '0;
                state <= S_T_RD;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          if (vidx == LAST_VOICE) state <= S_APPLY;
          else vidx <= vidx + 1'b1;
        end
        S_APPLY:  state <= S_IDLE;
        S_T_RD:   state <= S_T_MUL1;
        S_T_MUL1: state <= S_T_MUL2;
        S_T_MUL2: state <= S_T_ACC;
        S_T_ACC: begin
          if (vidx == LAST_VOICE) state <= S_T_DONE;
          else begin
            vidx  <= vidx + 1'b1;
            state <= S_T_RD;
          end
        end
        S_T_DONE: begin
          if (!stat.out_busy) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/pwvm_datapath.sv
module pwvm_datapath
  import pwvm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  output stat_t                      stat,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [14:0]                cfg_data,
  input  logic [2:0]                 mode,
  input  logic [5:0]                 button,
  input  logic [1:0]                 table_select,
  input  logic [10:0]                table_index,
  input  logic signed [15:0]         table_value,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic signed [SAMPLE_W-1:0] sample
);

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(OUT_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(OUT_MIN);

  // configuration
  logic [7:0]  bass_volume, chords_volume, melody_volume;
  logic [14:0] vibrato_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      bass_volume   <= 8'd200;
      chords_volume <= 8'd200;
      melody_volume <= 8'd200;
      vibrato_rate  <= 15'd200;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASS_VOL:   bass_volume   <= cfg_data[7:0];
        CFG_CHORDS_VOL: chords_volume <= cfg_data[7:0];
        CFG_MELODY_VOL: melody_volume <= cfg_data[7:0];
        CFG_VIB_RATE:   vibrato_rate  <= cfg_data;
        default: ;
      endcase
    end
  end

  // latched item
  logic [2:0]         l_mode;
  logic [5:0]         l_button;
  logic [1:0]         l_sel;
  logic [10:0]        l_idx;
  logic signed [15:0] l_val;

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LATCH) begin
      l_mode   <= mode;
      l_button <= button;
      l_sel    <= table_select;
      l_idx    <= table_index;
      l_val    <= table_value;
    end
  end

  // voice state
  logic               held   [NUM_VOICES];
  logic [5:0]         vbutton[NUM_VOICES];
  logic [31:0]        incr   [NUM_VOICES];
  logic [31:0]        phase  [NUM_VOICES];
  logic [RAMP_W-1:0]  ramp   [NUM_VOICES];

  logic               hit_v, free_v;
  logic [VOICE_W-1:0] hit_i, free_i;

  logic [15:0] vib_value;
  logic        vib_falling;
  logic [TICK_W-1:0] tick_count;

  // per-voice values at the scan / tick index
  logic [VOICE_W-1:0] v;
  logic               act;
  logic [RAMP_W-1:0]  rnew;
  logic [31:0]        vib_ext, vib_sh;
  logic [63:0]        idx_prod;
  logic [1:0]         tsel;
  logic [7:0]         vol;

  assign v       = cmd.vidx;
  assign act     = held[v] || (ramp[v] != '0);
  assign vib_ext = {{16{vib_value[15]}}, vib_value};
  assign vib_sh  = (v < VOICE_W'(2)) ? (vib_ext << 2) : (vib_ext << 3);
  assign idx_prod = {32'd0, phase[v]} * 64'(TABLE_SIZE);
  assign tsel    = (v == '0) ? 2'd0 : ((v == VOICE_W'(1)) ? 2'd1 : 2'd2);
  assign vol     = (v == '0) ? bass_volume :
                   ((v == VOICE_W'(1)) ? chords_volume : melody_volume);

  always_comb begin
    rnew = ramp[v];
    if (held[v]) begin
      if (ramp[v] < RAMP_W'(RAMP_STEPS)) rnew = ramp[v] + 1'b1;
    end else if (ramp[v] != '0) begin
      rnew = ramp[v] - 1'b1;
    end
  end

  // apply decode
  logic               r_ok, l_ok;
  logic [4:0]         lnote;
  logic               l_bass;
  logic [VOICE_W-1:0] l_voice;

  assign r_ok    = ({1'b0, l_button} < 7'(RIGHT_BUTTONS));
  assign l_ok    = (l_button < 6'(LEFT_COUNT));
  assign lnote   = left_note(l_button[4:0]);
  assign l_bass  = (lnote < 5'd12);
  assign l_voice = l_bass ? VOICE_W'(0) : VOICE_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        held[i]    <= 1'b0;
        vbutton[i] <= '0;
        incr[i]    <= '0;
        phase[i]   <= '0;
        ramp[i]    <= '0;
      end
      hit_v  <= 1'b0;
      free_v <= 1'b0;
      hit_i  <= '0;
      free_i <= '0;
    end else begin
      case (cmd.op)
        OP_LATCH: begin
          hit_v  <= 1'b0;
          free_v <= 1'b0;
        end
        OP_SCAN: begin
          if (held[v] && vbutton[v] == l_button && !hit_v) begin
            hit_v <= 1'b1;
            hit_i <= v;
          end
          if (!held[v] && ramp[v] == '0 && !free_v) begin
            free_v <= 1'b1;
            free_i <= v;
          end
        end
        OP_APPLY: begin
          case (l_mode)
            MODE_RIGHT_ON: begin
              if (r_ok && (hit_v || free_v)) begin
                held[hit_v ? hit_i : free_i]    <= 1'b1;
                vbutton[hit_v ? hit_i : free_i] <= l_button;
                incr[hit_v ? hit_i : free_i]    <= note_incr({1'b0, l_button} + 7'd14);
              end
            end
            MODE_RIGHT_OFF: begin
              if (r_ok && hit_v) held[hit_i] <= 1'b0;
            end
            MODE_LEFT_ON: begin
              if (l_ok) begin
                held[l_voice]    <= 1'b1;
                vbutton[l_voice] <= l_button;
                incr[l_voice]    <= note_incr({2'b00, lnote} + 7'd1);
              end
            end
            MODE_LEFT_OFF: begin
              if (l_ok) begin
                if (l_bass && held[0] && vbutton[0] == l_button) begin
                  held[0] <= 1'b0;
                  incr[0] <= '0;
                end else if (held[1] && vbutton[1] == l_button) begin
                  held[1] <= 1'b0;
                  incr[1] <= '0;
                end
              end
            end
            default: ;
          endcase
        end
        OP_T_RD: begin
          if (act) begin
            ramp[v]  <= rnew;
            phase[v] <= phase[v] + incr[v] + vib_sh;
          end
        end
        default: ;
      endcase
    end
  end

  // wave store with clearing sweep after reset
  logic signed [15:0] wave_mem[WAVE_DEPTH];
  logic [1:0]         clr_tab;
  logic [TIDX_W-1:0]  clr_idx;
  logic               mem_we;
  logic [WADDR_W-1:0] mem_wa, mem_ra;
  logic signed [15:0] mem_wd, rd_data;

  assign stat.clr_last = (clr_tab == 2'd2) && (clr_idx == TIDX_W'(TABLE_SIZE - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_tab <= '0;
      clr_idx <= '0;
    end else if (cmd.op == OP_CLEAR && !stat.clr_last) begin
      if (clr_idx == TIDX_W'(TABLE_SIZE - 1)) begin
        clr_idx <= '0;
        clr_tab <= clr_tab + 1'b1;
      end else begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = WADDR_W'(32'(clr_tab) * TABLE_SIZE + 32'(clr_idx));
    mem_wd = ({1'b0, clr_idx} < (TIDX_W + 1)'(TABLE_SIZE / 2)) ? 16'sd32767 : -16'sd32768;
    if (cmd.op == OP_CLEAR) begin
      mem_we = 1'b1;
    end else if (cmd.op == OP_APPLY && l_mode == MODE_TABLE && l_sel != 2'd3 &&
                 32'(l_idx) < TABLE_SIZE) begin
      mem_we = 1'b1;
      mem_wa = WADDR_W'(32'(l_sel) * TABLE_SIZE + 32'(l_idx));
      mem_wd = l_val;
    end
  end

  assign mem_ra = WADDR_W'(32'(tsel) * TABLE_SIZE + 32'(idx_prod[63:32]));

  always_ff @(posedge clk) begin
    if (mem_we) wave_mem[mem_wa] <= mem_wd;
    if (cmd.op == OP_T_RD) rd_data <= wave_mem[mem_ra];
  end

  // mix pipeline: ramp product, volume product, accumulate
  logic [RAMP_W-1:0]   ramp_r;
  logic [7:0]          vol_r;
  logic                act_r;
  logic signed [22:0]  p1;
  logic signed [31:0]  p2, term;
  logic signed [SUM_W-1:0] sum;

  assign term = p2 >>> 10;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_T_RD: begin
        ramp_r <= rnew;
        vol_r  <= vol;
        act_r  <= act;
      end
      OP_T_MUL1: p1 <= 23'(rd_data) * 23'($signed({1'b0, ramp_r}));
      OP_T_MUL2: p2 <= 32'(p1) * 32'($signed({1'b0, vol_r}));
      default: ;
    endcase
    if (cmd.op == OP_LATCH) sum <= '0;
    else if (cmd.op == OP_T_ACC && act_r) sum <= sum + {{(SUM_W - 32){term[31]}}, term};
  end

  // result register, tick count and vibrato
  logic [15:0]       vstep, vt;
  logic [TICK_W-1:0] tc_next;

  assign vstep   = vib_falling ? (16'd0 - {1'b0, vibrato_rate}) : {1'b0, vibrato_rate};
  assign vt      = vib_value + vstep;
  assign tc_next = tick_count + 1'b1;
  assign stat.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      vib_value   <= '0;
      vib_falling <= 1'b0;
      tick_count  <= '0;
    end else begin
      if (cmd.op == OP_T_FINISH) begin
        out_valid <= 1'b1;
        if (32'(tc_next) >= BUFFER_LEN) begin
          tick_count <= '0;
          if (vt[15]) begin
            vib_value   <= vib_value - vstep;
            vib_falling <= ~vib_falling;
          end else begin
            vib_value <= vt;
          end
        end else begin
          tick_count <= tc_next;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_T_FINISH) begin
      if (sum > SUM_MAX) sample <= SAMPLE_W'(SUM_MAX);
      else if (sum < SUM_MIN) sample <= SAMPLE_W'(SUM_MIN);
      else sample <= sum[SAMPLE_W-1:0];
    end
  end

endmodule

FILE: rtl/polyphonic_wavetable_voice_mixer_top.sv
// Channel  Handshake             Payload
// in       in_valid / in_stall   mode, button, table_select, table_index, table_value
// out      out_valid / out_stall sample (one item per sample tick)
// cfg      cfg_we                cfg_index, cfg_data (no read-back)
//
// In a sample tick the mixer walks the voices one at a time through a wave-store
// read, two multiplies and an accumulate.
// Right button events first scan the melody voices, then apply; left button and
// table items are applied directly, and unused modes are dropped.
// After reset the wave store is filled with square waves while in_stall is held
// high; configuration writes are taken throughout.
// A tick result waits in the output register; the block takes new items meanwhile
// and holds the next tick at its end until that register is free.
module polyphonic_wavetable_voice_mixer_top
  import pwvm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 mode,
  input  logic [5:0]                 button,
  input  logic [1:0]                 table_select,
  input  logic [10:0]                table_index,
  input  logic signed [15:0]         table_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] sample,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [14:0]                cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // sequence clear, scan, apply and per-voice tick steps
  pwvm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // hold voices, wave store, mixer and output register
  pwvm_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .button       (button),
    .table_select (table_select),
    .table_index  (table_index),
    .table_value  (table_value),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .sample       (sample)
  );

endmodule
